// ----- design/md5bs_pkg.sv -----
// md5bs_pkg: shared types, constants and round functions for the md5 byte stream hasher
// used by md5bs_core and the md5_byte_stream_hash top level; no dependencies
package md5bs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] chain_t;

  // commands from the sequencer to the compression engine
  typedef struct packed {
    logic start;
    logic init;
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // buffer word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] w;
    r4 = r[3:0];
    case (r[5:4])
      2'd0: w = r4;
      2'd1: w = 4'(r4 * 4'd5 + 4'd1);
      2'd2: w = 4'(r4 * 4'd3 + 4'd5);
      2'd3: w = 4'(r4 * 4'd7);
      default: w = r4;
    endcase
    return w;
  endfunction

  function automatic word_t round_f(input logic [1:0] phase, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    case (phase)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ----- design/md5bs_buf_ram.sv -----
// md5bs_buf_ram: 16 x 32 block buffer with byte write enables and registered read
// generic storage, no package dependencies
module md5bs_buf_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  be,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (we && be[i]) begin
        mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
  end

  // writes and compression reads never overlap, so no bypass
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/md5bs_core.sv -----
// md5bs_core: md5 compression engine, one round per cycle over the block buffer
// depends on md5bs_pkg; reads message words from md5bs_buf_ram through rd_addr/rd_data
module md5bs_core (
  input  logic                  clk,
  input  logic                  rst,
  input  md5bs_pkg::core_cmd_t  cmd,
  output md5bs_pkg::core_sts_t  sts,
  output logic [3:0]            rd_addr,
  input  logic [31:0]           rd_data,
  output md5bs_pkg::chain_t     chain
);
  import md5bs_pkg::*;

  localparam logic [6:0] CNT_LAST = 7'd66;

  logic [6:0] cnt;
  logic       busy;
  logic       done;
  word_t      a, b, c, d;
  word_t      pre;
  word_t      pre_next;
  word_t      sum;
  word_t      b_new;
  logic [5:0] k_idx;
  logic [5:0] rnd;
  logic       do_round;

  // the read for round cnt goes out ahead of that round, through the buffer read register and then pre
  assign rd_addr = msg_index(cnt[5:0]);
  assign k_idx   = cnt[5:0] - 6'd1;
  assign rnd     = cnt[5:0] - 6'd2;

  // a of the next round is the current d, except before the first round
  assign pre_next = ((cnt == 7'd1) ? a : d) + K_TAB[k_idx] + rd_data;
  assign sum      = pre + round_f(rnd[5:4], b, c, d);
  assign b_new    = b + rotl(sum, ROT_TAB[{rnd[5:4], rnd[1:0]}]);
  assign do_round = busy && (cnt >= 7'd2) && (cnt <= 7'd65);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      chain <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      done <= 1'b0;
      if (cmd.init) begin
        chain <= {IV_D, IV_C, IV_B, IV_A};
      end
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
        end else begin
          cnt <= cnt + 7'd1;
        end
      end
    end
  end

  // working words need no reset
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (do_round) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_new;
    end
    if (busy) begin
      pre <= pre_next;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- design/md5_byte_stream_hash.sv -----
// md5_byte_stream_hash: md5 over a byte stream, intake and padding sequencer, digest output
// depends on md5bs_pkg, md5bs_buf_ram and md5bs_core
//
// usage:
//   msg channel (msg_valid/msg_stall): data_byte, has_byte, last_byte. a transfer with
//   has_byte set appends data_byte; last_byte closes the message after that byte.
//   dig channel (dig_valid/dig_stall): four transfers per message, digest_word with
//   word_index 0..3, last_word on the fourth.
// timing:
//   a byte that does not fill a block or close the message leaves msg_stall low, so bytes stream at one per cycle.
//   the 64th byte of a block starts a compression: one round per cycle in the shared
//   round unit, reading the buffer memory one word per round, while msg_stall is high.
//   a last transfer pads with one buffer word write per cycle (up to 16), writes the
//   length as two words and runs one compression, or two when the tail leaves no room
//   for the length; then the first digest word shows.
//   the digest words leave from an output register; while dig_stall is high the word
//   holds and no new msg transfer is taken. after the fourth word the chaining value
//   returns to its initial value and the block is ready for the next message.
// reset: synchronous, clears the byte count, chaining value and all handshake state.
module md5_byte_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import md5bs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [3:0] LEN_LO_WORD = 4'd13;
  localparam logic [3:0] LAST_WORD   = 4'd15;

  logic [2:0]  state;
  logic [2:0]  ret;
  logic [60:0] count;
  logic [4:0]  wc;
  logic [3:0]  endw;
  logic        extra;
  logic        go;

  logic        msg_xfer;
  logic        dig_xfer;
  logic [5:0]  pos;
  logic [63:0] bit_len;

  logic        we;
  logic [3:0]  be;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;

  core_cmd_t   cmd;
  core_sts_t   sts;
  chain_t      chain;

  assign msg_stall = (state != S_IDLE);
  assign msg_xfer  = msg_valid && !msg_stall;
  assign dig_xfer  = dig_valid && !dig_stall;
  assign pos       = count[5:0];
  assign bit_len   = {count, 3'b000};

  assign cmd.start = go;
  assign cmd.init  = (state == S_EMIT) && dig_xfer && last_word;

  // buffer write port
  always_comb begin
    we    = 1'b0;
    be    = 4'h0;
    waddr = pos[5:2];
    wdata = '0;
    case (state)
      S_IDLE: begin
        we    = msg_xfer && has_byte;
        be    = 4'b0001 << pos[1:0];
        wdata = {4{data_byte}};
      end
      S_PAD: begin
        // pad byte in its lane, zeros in the lanes above
        we    = 1'b1;
        be    = 4'hF << pos[1:0];
        wdata = {24'h0, PAD_BYTE} << {pos[1:0], 3'b000};
      end
      S_ZERO: begin
        we    = !wc[4] && (wc[3:0] <= endw);
        be    = 4'hF;
        waddr = wc[3:0];
      end
      S_LEN: begin
        we    = 1'b1;
        be    = 4'hF;
        waddr = wc[3:0];
        wdata = wc[0] ? bit_len[63:32] : bit_len[31:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      count     <= '0;
      wc        <= '0;
      endw      <= LEN_LO_WORD;
      extra     <= 1'b0;
      go        <= 1'b0;
      dig_valid <= 1'b0;
    end else begin
      go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (msg_xfer) begin
            if (has_byte) begin
              count <= count + 61'd1;
              if (pos == 6'd63) begin
                go    <= 1'b1;
                state <= S_WAIT;
                ret   <= last_byte ? S_PAD : S_IDLE;
              end else if (last_byte) begin
                state <= S_PAD;
              end
            end else if (last_byte) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          wc    <= {1'b0, pos[5:2]} + 5'd1;
          extra <= (pos[5:3] == 3'b111);
          endw  <= (pos[5:3] == 3'b111) ? LAST_WORD : LEN_LO_WORD;
          state <= S_ZERO;
        end
        S_ZERO: begin
          if (!wc[4] && (wc[3:0] <= endw)) begin
            wc <= wc + 5'd1;
          end else if (extra) begin
            // no room for the length: compress, then clear words 0..13
            go    <= 1'b1;
            ret   <= S_ZERO;
            state <= S_WAIT;
            extra <= 1'b0;
            wc    <= '0;
            endw  <= LEN_LO_WORD;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (!wc[0]) begin
            wc <= wc + 5'd1;
          end else begin
            go    <= 1'b1;
            ret   <= S_EMIT;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sts.done) begin
            state <= ret;
            if (ret == S_EMIT) begin
              dig_valid <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (dig_xfer && last_word) begin
            dig_valid <= 1'b0;
            count     <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // digest payload registers
  always_ff @(posedge clk) begin
    if (state == S_WAIT && sts.done && ret == S_EMIT) begin
      digest_word <= swap32(chain[0]);
      word_index  <= 2'd0;
      last_word   <= 1'b0;
    end else if (state == S_EMIT && dig_xfer && !last_word) begin
      digest_word <= swap32(chain[word_index + 2'd1]);
      word_index  <= word_index + 2'd1;
      last_word   <= (word_index == 2'd2);
    end
  end

  md5bs_buf_ram u_buf (
    .clk   (clk),
    .we    (we),
    .be    (be),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  md5bs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .chain   (chain)
  );

endmodule

// ----- design/md5bs_check.sv -----
// md5bs_check: port-level checks for md5_byte_stream_hash, attached by bind
// no package dependencies
module md5bs_check (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_stall,
  input logic [7:0]  data_byte,
  input logic        has_byte,
  input logic        last_byte,
  input logic        dig_valid,
  input logic        dig_stall,
  input logic [31:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);

  // stalled digest transfer holds its word
  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_stall |=> dig_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // no message transfer while a digest is being delivered
  a_no_intake: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> msg_stall)
    else $error("message taken during digest output");

  // digest words follow each other in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && !last_word |=>
      dig_valid && (word_index == $past(word_index) + 2'd1))
    else $error("digest word index out of order");

  // the fourth word ends the digest
  a_digest_end: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_stall && last_word |=> !dig_valid && (word_index == 2'd3))
    else $error("digest continued past its last word");

  // a non-final byte never produces a digest right away
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && !last_byte |=> !dig_valid)
    else $error("digest without a last transfer");

endmodule

bind md5_byte_stream_hash md5bs_check u_md5bs_check (.*);

// ----- test/md5_byte_stream_hash_test.sv -----
// md5_byte_stream_hash_test: self-checking bench for the md5 byte stream hasher
// streams byte messages over the msg channel and checks every digest word against a local md5 model
// depends on md5bs_pkg (word type) and md5_byte_stream_hash
module md5_byte_stream_hash_test;
  import md5bs_pkg::word_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 200;
  localparam int TARGET_ITEMS = 170;
  localparam int TARGET_MESSAGES = 12;
  localparam int IDLE_PERCENT = 12;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    word_t      word;
    logic [1:0] index;
    logic       last_flag;
  } digest_entry_t;

  class md5_digest_model;
    word_t         chain[4];
    word_t         block[16];
    logic [60:0]   byte_count;
    word_t         sine_k[64];
    int unsigned   shift_amt[16];
    digest_entry_t digest_due[$];
    int            errors;

    function new();
      real s;
      for (int i = 0; i < 64; i++) begin
        s = $sin(i + 1);
        if (s < 0.0) s = -s;
        sine_k[i] = word_t'(longint'($floor(s * 4294967296.0)));
      end
      shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      foreach (block[i]) block[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      byte_count = '0;
    endfunction

    function void compress_block();
      word_t a, b, c, d, f, sum, tmp;
      int w, ph, s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        ph = r / 16;
        case (ph)
          0: begin
            f = (b & c) | (~b & d);
            w = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            w = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            w = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            w = (7 * r) % 16;
          end
        endcase
        sum = a + f + sine_k[r] + block[w];
        s = shift_amt[ph * 4 + r % 4];
        tmp = d;
        d = c;
        c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
        a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void put_byte(int pos, logic [7:0] v);
      block[pos / 4][8 * (pos % 4) +: 8] = v;
    endfunction

    // one accepted msg transfer; queues four digest words when it closes a message
    function void take_item(logic [7:0] d, logic h, logic l);
      int pos;
      logic [63:0] bit_len;
      digest_entry_t e;
      if (h) begin
        pos = int'(byte_count[5:0]);
        put_byte(pos, d);
        byte_count++;
        if (pos == 63) compress_block();
      end
      if (!l) return;
      pos = int'(byte_count[5:0]);
      put_byte(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      // no room left for the length: spill into one more block
      if (pos >= 56) begin
        compress_block();
        foreach (block[i]) block[i] = '0;
      end
      bit_len = {byte_count, 3'b000};
      block[14] = bit_len[31:0];
      block[15] = bit_len[63:32];
      compress_block();
      for (int i = 0; i < 4; i++) begin
        e.word = {chain[i][7:0], chain[i][15:8], chain[i][23:16], chain[i][31:24]};
        e.index = 2'(i);
        e.last_flag = (i == 3);
        digest_due.push_back(e);
      end
      restart();
    endfunction

    task flag_mismatch(string what, word_t got, word_t want);
      $display("mismatch on %s: got %h, want %h", what, got, want);
      errors++;
    endtask

    task check_digest_word(word_t w, logic [1:0] idx, logic lw);
      digest_entry_t e;
      if (digest_due.size() == 0) begin
        flag_mismatch("digest word with none due", w, '0);
        return;
      end
      e = digest_due.pop_front();
      if (w !== e.word) flag_mismatch("digest_word", w, e.word);
      if (idx !== e.index) flag_mismatch("word_index", word_t'(idx), word_t'(e.index));
      if (lw !== e.last_flag) flag_mismatch("last_word", word_t'(lw), word_t'(e.last_flag));
    endtask

    function int pending();
      return digest_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        dig_valid;
  logic        dig_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  md5_digest_model digests;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_cycles = 0;
  int items_sent = 0;
  int cycle_count = 0;

  md5_byte_stream_hash dut (
    .clk(clk),
    .rst(rst),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .last_byte(last_byte),
    .dig_valid(dig_valid),
    .dig_stall(dig_stall),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_word(last_word)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_cycles = HOLD_OFF_CYCLES;
    end
    if (hold_cycles > 0) begin
      dig_stall <= 1'b1;
      hold_cycles--;
    end else begin
      dig_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst && dig_valid && !dig_stall) digests.check_digest_word(digest_word, word_index, last_word);
  end

  task automatic send_item(input logic [7:0] d, input logic h, input logic l);
    @(negedge clk);
    while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
      msg_valid <= 1'b0;
      data_byte <= 8'($urandom);
      has_byte <= 1'($urandom);
      last_byte <= 1'($urandom);
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    data_byte <= d;
    has_byte <= h;
    last_byte <= l;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    digests.take_item(d, h, l);
    if (h || l) items_sent++;
  endtask

  task automatic stop_offering();
    @(negedge clk);
    msg_valid <= 1'b0;
  endtask

  task automatic wait_digests_drained();
    stop_offering();
    while (digests.pending() != 0) @(posedge clk);
  endtask

  // random bytes, the closing mark either on the final byte or on a transfer of its own
  task automatic send_message(int len);
    bit tail_byte;
    tail_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, tail_byte && (i == len - 1));
    end
    if (!tail_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int msg_count;
    int len;
    digests = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty message, then a transfer with neither byte nor close
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'ha5, 1'b0, 1'b0);
    // "abc" closed on its final byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // byte extremes with an ignored transfer between them, closed without a byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    wait_digests_drained();

    msg_count = 0;
    while (items_sent < TARGET_ITEMS || msg_count < TARGET_MESSAGES) begin
      len = $urandom_range(5);
      // tail past byte 56 forces the extra padding block; a full block compresses mid-message
      if (msg_count == 1) len = 57;
      if (msg_count == 4) len = 64;
      if (msg_count == 3) hold_requests++;
      if (msg_count == 6) wait_digests_drained();
      tx_idle_en = (msg_count < 8) || (msg_count > 10);
      rx_idle_en = tx_idle_en;
      send_message(len);
      msg_count++;
    end

    stop_offering();
    while (digests.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digests.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
